// File: design/lsbp_pkg.sv
package lsbp_pkg;

	localparam logic [7:0] DescSync1 = 8'hA5;
	localparam logic [7:0] DescSync2 = 8'h5A;
	localparam logic [2:0] DescLen = 3'd7;
	localparam logic [2:0] PktLast = 3'd4;
	localparam logic [1:0] SyncInvalid = 2'b11;

	localparam int unsigned DataWidth = 40;
	localparam int unsigned UserWidth = 2;

	typedef struct packed {
		logic        new_revolution;
		logic        has_distance;
		logic [5:0]  quality;
		logic [14:0] angle_fx;
		logic [15:0] distance_q2;
	} point_t;

endpackage

// File: design/lidar_scan_byte_parser.sv
// Scan packet parser for a rotating range sensor. It takes one byte per cycle
// on the slave stream, first hunting for the 7-byte response descriptor that
// opens with A5h 5Ah, and from then on assembling 5-byte scan packets; each
// complete packet gives one point request, presented on the master stream from
// the point register after its last byte has passed the byte register. The
// byte register and the point register each stand behind their own handshake,
// so a new byte is taken in every cycle while the point register is empty or
// being drained; the parse step between the two registers is combinational.
module lidar_scan_byte_parser
	import lsbp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,  // rx_byte
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [DataWidth-1:0] m_tdata,  // quality, angle_fx, distance_q2, zero fill
	output logic [UserWidth-1:0] m_tuser   // new_revolution, has_distance
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	logic       scan_q;
	logic [2:0] desc_cnt_q;
	logic [2:0] pkt_cnt_q;
	logic [7:0] pkt_bytes_q [4];

	logic       scan_d;
	logic [2:0] desc_cnt_d;
	logic [2:0] pkt_cnt_d;
	logic       store_en;
	logic       emit;
	point_t     point;

	logic       out_valid_q;
	point_t     out_point_q;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	always_comb begin
		scan_d     = scan_q;
		desc_cnt_d = desc_cnt_q;
		pkt_cnt_d  = pkt_cnt_q;
		store_en   = 1'b0;
		emit       = 1'b0;
		if (!scan_q) begin
			if (desc_cnt_q == 3'd0 && byte_s1 != DescSync1) begin
				desc_cnt_d = 3'd0;
			end else if (desc_cnt_q == 3'd1 && byte_s1 != DescSync2) begin
				desc_cnt_d = 3'd0;
			end else begin
				desc_cnt_d = desc_cnt_q + 3'd1;
				if (desc_cnt_d == DescLen) begin
					scan_d    = 1'b1;
					pkt_cnt_d = 3'd0;
				end
			end
		end else begin
			case (pkt_cnt_q)
				3'd0: begin
					if (byte_s1[1:0] != SyncInvalid) begin
						store_en  = 1'b1;
						pkt_cnt_d = 3'd1;
					end
				end
				3'd1: begin
					if (byte_s1[0]) begin
						store_en  = 1'b1;
						pkt_cnt_d = 3'd2;
					end else begin
						pkt_cnt_d = 3'd0;
					end
				end
				3'd2, 3'd3: begin
					store_en  = 1'b1;
					pkt_cnt_d = pkt_cnt_q + 3'd1;
				end
				default: begin
					emit      = 1'b1;
					pkt_cnt_d = 3'd0;
				end
			endcase
		end
	end

	always_comb begin
		point.new_revolution = pkt_bytes_q[0][0];
		point.quality        = pkt_bytes_q[0][7:2];
		point.angle_fx       = {pkt_bytes_q[2], pkt_bytes_q[1][7:1]};
		point.distance_q2    = {byte_s1, pkt_bytes_q[3]};
		point.has_distance   = ({byte_s1, pkt_bytes_q[3]} != 16'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= 1'b0;
			desc_cnt_q <= 3'd0;
			pkt_cnt_q  <= 3'd0;
		end else if (valid_s1 && advance) begin
			scan_q     <= scan_d;
			desc_cnt_q <= desc_cnt_d;
			pkt_cnt_q  <= pkt_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && store_en) begin
			pkt_bytes_q[pkt_cnt_q[1:0]] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			out_point_q <= point;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {out_point_q.has_distance, out_point_q.new_revolution};
	assign m_tdata  = {3'd0, out_point_q.distance_q2, out_point_q.angle_fx,
		out_point_q.quality};

`ifndef SYNTHESIS
	// The packet counter never runs past the fifth byte.
	assert property (@(posedge clk) disable iff (!arst_n) pkt_cnt_q <= PktLast)
		else $error("packet counter out of range");

	// No packet is assembled while the descriptor is still being hunted.
	assert property (@(posedge clk) disable iff (!arst_n) !scan_q |-> pkt_cnt_q == 3'd0)
		else $error("packet bytes counted before descriptor");

	// The hunt never reaches the full descriptor length without entering scanning.
	assert property (@(posedge clk) disable iff (!arst_n) !scan_q |-> desc_cnt_q != DescLen)
		else $error("descriptor count complete but not scanning");

	// A point request only follows a fifth packet byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pkt_cnt_q) == PktLast && scan_q)
		else $error("point request without a complete packet");
`endif

endmodule
